// File: src/cbwp_pkg.sv
// ----------------------------------------------------------------------------
// cbwp_pkg: shared types and constants
// Sequencer states, command and register codes, reset values and default
// widths of the wandering B-spline path block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbwp_pkg;

   localparam int PHASE_BITS_DEF = 16;
   localparam int COORD_BITS_DEF = 32;

   localparam int SPLIT_BITS = 24;
   localparam int MUL_A_W    = 32;
   localparam int PT_W       = 50;
   localparam int OFF_W      = 34;
   localparam int POS_W      = 32;
   localparam int RATE_W     = 24;
   localparam int HALF_W     = 31;
   localparam int RAND_W     = 16;
   localparam int DELTA_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int NEW_PT_SHIFT  = 15;
   localparam int DIR_PT_SHIFT  = 17;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE     = 3'd6;

   localparam logic [HALF_W-1:0] HALF_RESET = 31'd65536;
   localparam logic [RATE_W-1:0] RATE_RESET = 24'd16777;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_PTS,
      ST_RST,
      ST_WGT,
      ST_EVAL,
      ST_DINIT,
      ST_DIV,
      ST_SAVE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: src/cbwp_mul.sv
// ----------------------------------------------------------------------------
// cbwp_mul: shared signed multiplier
// Signed product of two operands, registered once.
// ----------------------------------------------------------------------------
`default_nettype none

module cbwp_mul #(
   parameter int A_W = 32,
   parameter int B_W = 20
) (
   input  wire                       clock,
   input  wire  signed [A_W-1:0]     a,
   input  wire  signed [B_W-1:0]     b,
   output logic signed [A_W+B_W-1:0] p
);

   logic signed [A_W+B_W-1:0] p_ff;
   logic signed [A_W+B_W-1:0] p_in;

   assign p_in = (A_W+B_W)'(a) * (A_W+B_W)'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// File: src/cubic_bspline_wander_path.sv
// ----------------------------------------------------------------------------
// cubic_bspline_wander_path: wandering 3D position on a uniform cubic B-spline
// Four sliding control points per axis inside a box around a centre; a tick
// advances the phase and appends a random point on wrap, a restart rebuilds
// the path about the centre. Each beat in gives one position beat out.
// ----------------------------------------------------------------------------
// One item at a time through a single shared signed multiplier under a small
// sequencer; req_stall is high from acceptance until the result is staged.
// Each product is registered before it is used. The divide-by-three unit
// works on ND radix-16 digits, ceil((max(COORD_BITS,25)+6)/4): 10 at the
// defaults. The result waits in an output register, so the next beat is
// taken while it is still stalled.
`default_nettype none

module cubic_bspline_wander_path #(
   parameter int PHASE_BITS = cbwp_pkg::PHASE_BITS_DEF,
   parameter int COORD_BITS = cbwp_pkg::COORD_BITS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire                                    req_cmd,
   input  wire         [cbwp_pkg::DELTA_W-1:0]    req_delta_time,
   input  wire  signed [cbwp_pkg::RAND_W-1:0]     req_rand_a_x,
   input  wire  signed [cbwp_pkg::RAND_W-1:0]     req_rand_a_y,
   input  wire  signed [cbwp_pkg::RAND_W-1:0]     req_rand_a_z,
   input  wire  signed [cbwp_pkg::RAND_W-1:0]     req_rand_b_x,
   input  wire  signed [cbwp_pkg::RAND_W-1:0]     req_rand_b_y,
   input  wire  signed [cbwp_pkg::RAND_W-1:0]     req_rand_b_z,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic signed [cbwp_pkg::POS_W-1:0]      rsp_pos_x,
   output logic signed [cbwp_pkg::POS_W-1:0]      rsp_pos_y,
   output logic signed [cbwp_pkg::POS_W-1:0]      rsp_pos_z,
   output logic                                   rsp_advanced,
   input  wire                                    csr_we,
   input  wire         [cbwp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire         [cbwp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int PB     = PHASE_BITS;
   localparam int C      = COORD_BITS;
   localparam int A_W    = cbwp_pkg::MUL_A_W;
   localparam int B_W    = (PB + 4 > 17) ? PB + 4 : 17;
   localparam int P_W    = A_W + B_W;
   localparam int WX     = B_W + 2;
   localparam int PW     = (C > cbwp_pkg::SPLIT_BITS) ? C : cbwp_pkg::SPLIT_BITS + 1;
   localparam int HW     = PW - cbwp_pkg::SPLIT_BITS;
   localparam int ACC_N  = PW + PB + 6;
   localparam int ACC_W  = (ACC_N > P_W) ? ACC_N : P_W;
   localparam int QW     = PW + 5;
   localparam int ND     = (QW + 1 + 3) / 4;
   localparam int UW     = ND * 4;
   localparam int DIG_W  = $clog2(ND);
   localparam int SAT_W  = (C < cbwp_pkg::POS_W) ? C : cbwp_pkg::POS_W;
   localparam int PT_W   = cbwp_pkg::PT_W;
   localparam int OFF_W  = cbwp_pkg::OFF_W;
   localparam int SH_STEP = cbwp_pkg::RATE_W - PB;

   localparam logic signed [PT_W-1:0] PT_HI = PT_W'({(C-1){1'b1}});
   localparam logic signed [PT_W-1:0] PT_LO = ~PT_HI;
   localparam logic signed [UW:0]     R_HI  = (UW+1)'({(SAT_W-1){1'b1}});
   localparam logic signed [UW:0]     R_LO  = ~R_HI;
   localparam logic signed [UW:0]     BIAS3 = (UW+1)'(3) <<< (QW-1);
   localparam logic signed [UW:0]     BIAS1 = (UW+1)'(1) <<< (QW-1);
   localparam logic [39:0]            STEP_MAX = (40'd1 << PB) - 40'd1;
   localparam logic signed [WX-1:0]   S_X = WX'(1) <<< PB;

   cbwp_pkg::state_type state_ff, state_in;

   logic [2:0]       cnt_ff, cnt_in;
   logic [1:0]       ax_ff, ax_in;
   logic             sub_ff, sub_in;
   logic [DIG_W-1:0] dig_ff, dig_in;

   logic signed [31:0]                 center_ff [3];
   logic        [cbwp_pkg::HALF_W-1:0] half_ff [3];
   logic        [cbwp_pkg::RATE_W-1:0] rate_ff;

   logic [PB-1:0]          phase_ff, phase_in;
   logic signed [C-1:0]    ctrl_ff [3][4];
   logic signed [C-1:0]    ctrl_in [3][4];

   logic                   cmd_ff, cmd_in;
   logic [cbwp_pkg::DELTA_W-1:0] delta_ff, delta_in;
   logic signed [cbwp_pkg::RAND_W-1:0] ra_ff [3];
   logic signed [cbwp_pkg::RAND_W-1:0] ra_in [3];
   logic signed [cbwp_pkg::RAND_W-1:0] rb_ff [3];
   logic signed [cbwp_pkg::RAND_W-1:0] rb_in [3];
   logic                   adv_ff, adv_in;

   logic [PB-1:0]          t2_ff, t2_in;
   logic signed [B_W-1:0]  w_ff [4];
   logic signed [B_W-1:0]  w_in [4];
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [UW-1:0]          u_ff, u_in;
   logic [UW-1:0]          q_ff, q_in;
   logic [1:0]             rem_ff, rem_in;
   logic signed [cbwp_pkg::POS_W-1:0] pos_ff [3];
   logic signed [cbwp_pkg::POS_W-1:0] pos_in [3];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [cbwp_pkg::POS_W-1:0] rsp_pos_ff [3];
   logic signed [cbwp_pkg::POS_W-1:0] rsp_pos_in [3];
   logic                   rsp_adv_ff, rsp_adv_in;

   logic signed [A_W-1:0]  mul_a;
   logic signed [B_W-1:0]  mul_b;
   logic signed [P_W-1:0]  prod;

   logic signed [PW-1:0]   p_ext;
   logic signed [HW-1:0]   p_hi;
   logic [cbwp_pkg::SPLIT_BITS-1:0] p_lo;
   logic signed [OFF_W-1:0] off_new;
   logic signed [OFF_W-1:0] off_dir;
   logic signed [PT_W-1:0]  c_ext;
   logic signed [C-1:0]     pt_new;
   logic signed [C-1:0]     pt_plus;
   logic signed [C-1:0]     pt_minus;
   logic signed [C-1:0]     pt_center;
   logic [39:0]             step_raw;
   logic [39:0]             step_cl;
   logic [PB:0]             phase_sum;
   logic [PB-1:0]           t3;
   logic signed [WX-1:0]    t_x, t2_x, t3_x;
   logic signed [WX-1:0]    w0_x, w1_x, w2_x, w3_x;
   logic signed [ACC_W-1:0] term;
   logic signed [UW:0]      ux;
   logic [3:0]              digit;
   logic [5:0]              v;
   logic [11:0]             vm;
   logic [3:0]              qd;
   logic signed [UW:0]      r_x;
   logic signed [SAT_W-1:0] r_sat;

   function automatic logic signed [C-1:0] sat_pt(input logic signed [PT_W-1:0] x);
      logic signed [PT_W-1:0] y;
      begin
         y = x;
         if (x > PT_HI) begin
            y = PT_HI;
         end else if (x < PT_LO) begin
            y = PT_LO;
         end
         return C'(y);
      end
   endfunction

   cbwp_mul #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   // operand selection
   assign p_ext = PW'(ctrl_ff[ax_ff][cnt_ff[2:1]]);
   assign p_hi  = HW'(p_ext >>> cbwp_pkg::SPLIT_BITS);
   assign p_lo  = p_ext[cbwp_pkg::SPLIT_BITS-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         cbwp_pkg::ST_STEP: begin
            mul_a = A_W'($signed({1'b0, rate_ff}));
            mul_b = B_W'($signed({1'b0, delta_ff}));
         end
         cbwp_pkg::ST_PTS: begin
            mul_a = A_W'($signed({1'b0, half_ff[ax_ff]}));
            mul_b = B_W'(ra_ff[ax_ff]);
         end
         cbwp_pkg::ST_RST: begin
            mul_a = A_W'($signed({1'b0, half_ff[ax_ff]}));
            mul_b = cnt_ff[0] ? B_W'(rb_ff[ax_ff]) : B_W'(ra_ff[ax_ff]);
         end
         cbwp_pkg::ST_WGT: begin
            mul_a = cnt_ff[0] ? A_W'($signed({1'b0, t2_ff})) : A_W'($signed({1'b0, phase_ff}));
            mul_b = B_W'($signed({1'b0, phase_ff}));
         end
         cbwp_pkg::ST_EVAL: begin
            mul_a = cnt_ff[0] ? A_W'(p_hi) : A_W'($signed({1'b0, p_lo}));
            mul_b = w_ff[cnt_ff[2:1]];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // point, step and weight arithmetic on the registered product
   assign off_new   = OFF_W'(prod >>> cbwp_pkg::NEW_PT_SHIFT);
   assign off_dir   = OFF_W'(prod >>> cbwp_pkg::DIR_PT_SHIFT);
   assign c_ext     = PT_W'(center_ff[ax_ff]);
   assign pt_new    = sat_pt(c_ext + PT_W'(off_new));
   assign pt_plus   = sat_pt(c_ext + PT_W'(off_dir));
   assign pt_minus  = sat_pt(c_ext - PT_W'(off_dir));
   assign pt_center = sat_pt(c_ext);

   assign step_raw  = prod[39:0] >> SH_STEP;
   assign step_cl   = (step_raw > STEP_MAX) ? STEP_MAX : step_raw;
   assign phase_sum = {1'b0, phase_ff} + {1'b0, step_cl[PB-1:0]};

   assign t3   = prod[2*PB-1:PB];
   assign t_x  = $signed(WX'(phase_ff));
   assign t2_x = $signed(WX'(t2_ff));
   assign t3_x = $signed(WX'(t3));
   assign w0_x = S_X - ((t_x <<< 1) + t_x) + ((t2_x <<< 1) + t2_x) - t3_x;
   assign w1_x = (S_X <<< 2) - ((t2_x <<< 2) + (t2_x <<< 1)) + ((t3_x <<< 1) + t3_x);
   assign w2_x = S_X + ((t_x <<< 1) + t_x) + ((t2_x <<< 1) + t2_x)
                 - ((t3_x <<< 1) + t3_x);
   assign w3_x = t3_x;

   assign term = cnt_ff[0] ? (ACC_W'(prod) <<< cbwp_pkg::SPLIT_BITS) : ACC_W'(prod);

   // floor divide by three, one radix-16 digit a cycle
   assign ux    = (UW+1)'(QW'(acc_ff >>> (PB + 1))) + BIAS3;
   assign digit = u_ff[UW-1 -: 4];
   assign v     = {rem_ff, digit};
   assign vm    = 12'(v) * 12'd43;
   assign qd    = vm[10:7];

   assign r_x   = $signed({1'b0, q_ff}) - BIAS1;
   assign r_sat = (r_x > R_HI) ? SAT_W'(R_HI) : ((r_x < R_LO) ? SAT_W'(R_LO) : SAT_W'(r_x));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ax_in        = ax_ff;
      sub_in       = sub_ff;
      dig_in       = dig_ff;
      phase_in     = phase_ff;
      ctrl_in      = ctrl_ff;
      cmd_in       = cmd_ff;
      delta_in     = delta_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      adv_in       = adv_ff;
      t2_in        = t2_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      u_in         = u_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_adv_in   = rsp_adv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         cbwp_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               delta_in = req_delta_time;
               ra_in[0] = req_rand_a_x;
               ra_in[1] = req_rand_a_y;
               ra_in[2] = req_rand_a_z;
               rb_in[0] = req_rand_b_x;
               rb_in[1] = req_rand_b_y;
               rb_in[2] = req_rand_b_z;
               adv_in   = 1'b0;
               cnt_in   = '0;
               ax_in    = '0;
               sub_in   = 1'b0;
               state_in = (req_cmd == cbwp_pkg::CMD_RESTART) ? cbwp_pkg::ST_RST
                                                             : cbwp_pkg::ST_STEP;
            end
         end
         cbwp_pkg::ST_STEP: begin
            sub_in = ~sub_ff;
            if (sub_ff) begin
               phase_in = phase_sum[PB-1:0];
               cnt_in   = '0;
               if (phase_sum[PB]) begin
                  adv_in   = 1'b1;
                  state_in = cbwp_pkg::ST_PTS;
               end else begin
                  state_in = cbwp_pkg::ST_WGT;
               end
            end
         end
         cbwp_pkg::ST_PTS: begin
            sub_in = ~sub_ff;
            if (sub_ff) begin
               ctrl_in[ax_ff][0] = ctrl_ff[ax_ff][1];
               ctrl_in[ax_ff][1] = ctrl_ff[ax_ff][2];
               ctrl_in[ax_ff][2] = ctrl_ff[ax_ff][3];
               ctrl_in[ax_ff][3] = pt_new;
               if (ax_ff == 2'd2) begin
                  ax_in    = '0;
                  state_in = cbwp_pkg::ST_WGT;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end
         end
         cbwp_pkg::ST_RST: begin
            sub_in = ~sub_ff;
            if (sub_ff) begin
               phase_in = '0;
               cnt_in   = {2'b00, ~cnt_ff[0]};
               if (!cnt_ff[0]) begin
                  ctrl_in[ax_ff][0] = pt_minus;
                  ctrl_in[ax_ff][1] = pt_center;
                  ctrl_in[ax_ff][2] = pt_plus;
               end else begin
                  ctrl_in[ax_ff][3] = pt_new;
                  if (ax_ff == 2'd2) begin
                     ax_in    = '0;
                     state_in = cbwp_pkg::ST_WGT;
                  end else begin
                     ax_in = ax_ff + 2'd1;
                  end
               end
            end
         end
         cbwp_pkg::ST_WGT: begin
            sub_in = ~sub_ff;
            if (sub_ff) begin
               if (!cnt_ff[0]) begin
                  t2_in  = prod[2*PB-1:PB];
                  cnt_in = 3'd1;
               end else begin
                  w_in[0]  = B_W'(w0_x);
                  w_in[1]  = B_W'(w1_x);
                  w_in[2]  = B_W'(w2_x);
                  w_in[3]  = B_W'(w3_x);
                  cnt_in   = '0;
                  ax_in    = '0;
                  state_in = cbwp_pkg::ST_EVAL;
               end
            end
         end
         cbwp_pkg::ST_EVAL: begin
            sub_in = ~sub_ff;
            if (sub_ff) begin
               acc_in = (cnt_ff == 3'd0) ? term : acc_ff + term;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  state_in = cbwp_pkg::ST_DINIT;
               end
            end
         end
         cbwp_pkg::ST_DINIT: begin
            u_in     = UW'(ux);
            q_in     = '0;
            rem_in   = '0;
            dig_in   = '0;
            state_in = cbwp_pkg::ST_DIV;
         end
         cbwp_pkg::ST_DIV: begin
            rem_in = 2'(v - ({2'b00, qd} << 1) - {2'b00, qd});
            q_in   = {q_ff[UW-5:0], qd};
            u_in   = u_ff << 4;
            dig_in = dig_ff + DIG_W'(1);
            if (dig_ff == DIG_W'(ND - 1)) begin
               state_in = cbwp_pkg::ST_SAVE;
            end
         end
         cbwp_pkg::ST_SAVE: begin
            pos_in[ax_ff] = cbwp_pkg::POS_W'(r_sat);
            cnt_in        = '0;
            sub_in        = 1'b0;
            if (ax_ff == 2'd2) begin
               state_in = cbwp_pkg::ST_DONE;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = cbwp_pkg::ST_EVAL;
            end
         end
         cbwp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_pos_in   = pos_ff;
               rsp_adv_in   = adv_ff;
               rsp_valid_in = 1'b1;
               state_in     = cbwp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbwp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbwp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ax_ff        <= '0;
         sub_ff       <= 1'b0;
         dig_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 4; k++) begin
               ctrl_ff[i][k] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ax_ff        <= ax_in;
         sub_ff       <= sub_in;
         dig_ff       <= dig_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff      <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      delta_ff   <= delta_in;
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      adv_ff     <= adv_in;
      t2_ff      <= t2_in;
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      u_ff       <= u_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      pos_ff     <= pos_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_adv_ff <= rsp_adv_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            center_ff[i] <= '0;
            half_ff[i]   <= cbwp_pkg::HALF_RESET;
         end
         rate_ff <= cbwp_pkg::RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cbwp_pkg::CSR_CENTER_X: center_ff[0] <= $signed(csr_wdata);
            cbwp_pkg::CSR_CENTER_Y: center_ff[1] <= $signed(csr_wdata);
            cbwp_pkg::CSR_CENTER_Z: center_ff[2] <= $signed(csr_wdata);
            cbwp_pkg::CSR_HALF_X:   half_ff[0]   <= csr_wdata[cbwp_pkg::HALF_W-1:0];
            cbwp_pkg::CSR_HALF_Y:   half_ff[1]   <= csr_wdata[cbwp_pkg::HALF_W-1:0];
            cbwp_pkg::CSR_HALF_Z:   half_ff[2]   <= csr_wdata[cbwp_pkg::HALF_W-1:0];
            cbwp_pkg::CSR_RATE:     rate_ff      <= csr_wdata[cbwp_pkg::RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall    = (state_ff != cbwp_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_x    = rsp_pos_ff[0];
   assign rsp_pos_y    = rsp_pos_ff[1];
   assign rsp_pos_z    = rsp_pos_ff[2];
   assign rsp_advanced = rsp_adv_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != cbwp_pkg::ST_IDLE))
      else $error("sequencer idle after accepting a beat");

   a_shift_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbwp_pkg::ST_PTS) |-> (cmd_ff == cbwp_pkg::CMD_TICK))
      else $error("control point shift during a restart");

   a_restart_phase_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbwp_pkg::ST_WGT && cmd_ff == cbwp_pkg::CMD_RESTART)
      |-> (phase_ff == '0))
      else $error("phase not cleared by restart");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbwp_pkg::ST_DIV) |-> (rem_ff != 2'd3))
      else $error("divide-by-three remainder out of range");

   a_result_staged_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == cbwp_pkg::ST_DONE))
      else $error("result staged outside the final state");

endmodule

`default_nettype wire

// File: tb/sv/tb_cubic_bspline_wander_path.sv
// ----------------------------------------------------------------------------
// tb_cubic_bspline_wander_path: self-checking bench for the wandering path
// Drives ticks and restarts through the request channel while an in-bench
// predictor follows phase, control points and register settings; each
// position beat is checked against the oldest prediction. Both channels idle
// and stall at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cubic_bspline_wander_path;

   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 1500;

   typedef logic signed [cbwp_pkg::RAND_W-1:0]  rand_type;
   typedef logic        [cbwp_pkg::DELTA_W-1:0] delta_type;
   typedef logic        [cbwp_pkg::CSR_IDX_W-1:0] csr_idx_type;
   typedef logic        [cbwp_pkg::CSR_DATA_W-1:0] csr_data_type;

   typedef struct {
      logic signed [cbwp_pkg::POS_W-1:0] x;
      logic signed [cbwp_pkg::POS_W-1:0] y;
      logic signed [cbwp_pkg::POS_W-1:0] z;
      logic                              adv;
   } pos_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = cbwp_pkg::CMD_TICK;
   delta_type req_delta_time = '0;
   rand_type req_rand_a_x = '0, req_rand_a_y = '0, req_rand_a_z = '0;
   rand_type req_rand_b_x = '0, req_rand_b_y = '0, req_rand_b_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [cbwp_pkg::POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic rsp_advanced;
   logic csr_we = 1'b0;
   csr_idx_type csr_index = '0;
   csr_data_type csr_wdata = '0;

   cubic_bspline_wander_path dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_delta_time(req_delta_time),
      .req_rand_a_x(req_rand_a_x), .req_rand_a_y(req_rand_a_y), .req_rand_a_z(req_rand_a_z),
      .req_rand_b_x(req_rand_b_x), .req_rand_b_y(req_rand_b_y), .req_rand_b_z(req_rand_b_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_advanced(rsp_advanced),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   longint centre [3];
   longint half_ext [3];
   longint seg_rate;
   longint path_phase;
   longint ctrl_pt [3][4];

   pos_beat_type pending_pos [$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   int hold_asks = 0;
   int hold_done = 0;
   int hold_left = 0;
   int stall_left = 0;

   function automatic longint floor_div(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint box_point(int ax, longint r, int shift, bit negate);
      longint off;
      off = (half_ext[ax] * r) >>> shift;
      return clamp32(centre[ax] + (negate ? -off : off));
   endfunction

   function automatic pos_beat_type predict_position(logic cmd, delta_type dt,
                                                     longint ra [3], longint rb [3]);
      pos_beat_type res;
      longint stp, t, t2, t3, a, b, ph, pl, qa, rem, r;
      longint w [4];
      longint pos [3];
      res.adv = 1'b0;
      if (cmd == cbwp_pkg::CMD_RESTART) begin
         for (int ax = 0; ax < 3; ax++) begin
            ctrl_pt[ax][0] = box_point(ax, ra[ax], cbwp_pkg::DIR_PT_SHIFT, 1'b1);
            ctrl_pt[ax][1] = clamp32(centre[ax]);
            ctrl_pt[ax][2] = box_point(ax, ra[ax], cbwp_pkg::DIR_PT_SHIFT, 1'b0);
            ctrl_pt[ax][3] = box_point(ax, rb[ax], cbwp_pkg::NEW_PT_SHIFT, 1'b0);
         end
         path_phase = 0;
      end else begin
         stp = (longint'(dt) * seg_rate) >> 8;
         if (stp > 65535) stp = 65535;
         path_phase = path_phase + stp;
         if (path_phase >= 65536) begin
            path_phase = path_phase - 65536;
            res.adv = 1'b1;
            for (int ax = 0; ax < 3; ax++) begin
               for (int k = 0; k < 3; k++) ctrl_pt[ax][k] = ctrl_pt[ax][k+1];
               ctrl_pt[ax][3] = box_point(ax, ra[ax], cbwp_pkg::NEW_PT_SHIFT, 1'b0);
            end
         end
      end
      t = path_phase;
      t2 = (t * t) >> 16;
      t3 = (t2 * t) >> 16;
      w[0] = 65536 - 3*t + 3*t2 - t3;
      w[1] = 4*65536 - 6*t2 + 3*t3;
      w[2] = 65536 + 3*t + 3*t2 - 3*t3;
      w[3] = t3;
      for (int ax = 0; ax < 3; ax++) begin
         a = 0;
         b = 0;
         for (int k = 0; k < 4; k++) begin
            ph = ctrl_pt[ax][k] >>> 24;
            pl = ctrl_pt[ax][k] - ph * (64'sd1 << 24);
            a = a + ph * w[k];
            b = b + pl * w[k];
         end
         qa = floor_div(a, 6*65536);
         rem = a - qa * (6*65536);
         r = qa * (64'sd1 << 24) + floor_div(rem * (64'sd1 << 24) + b, 6*65536);
         pos[ax] = clamp32(r);
      end
      res.x = pos[0][31:0];
      res.y = pos[1][31:0];
      res.z = pos[2][31:0];
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(20, 120);
   endfunction

   // sender: called at a rising edge, returns at the edge of acceptance, or after the random idle gap that follows it
   task automatic send_beat(logic cmd, delta_type dt,
                            rand_type ax, rand_type ay, rand_type az,
                            rand_type bx, rand_type by, rand_type bz);
      longint ra [3];
      longint rb [3];
      int gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_delta_time <= dt;
      req_rand_a_x <= ax;
      req_rand_a_y <= ay;
      req_rand_a_z <= az;
      req_rand_b_x <= bx;
      req_rand_b_y <= by;
      req_rand_b_z <= bz;
      do @(posedge clock); while (req_stall);
      ra[0] = ax; ra[1] = ay; ra[2] = az;
      rb[0] = bx; rb[1] = by; rb[2] = bz;
      pending_pos.push_back(predict_position(cmd, dt, ra, rb));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, csr_data_type val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         cbwp_pkg::CSR_CENTER_X: centre[0] = longint'(signed'(val));
         cbwp_pkg::CSR_CENTER_Y: centre[1] = longint'(signed'(val));
         cbwp_pkg::CSR_CENTER_Z: centre[2] = longint'(signed'(val));
         cbwp_pkg::CSR_HALF_X:   half_ext[0] = val[cbwp_pkg::HALF_W-1:0];
         cbwp_pkg::CSR_HALF_Y:   half_ext[1] = val[cbwp_pkg::HALF_W-1:0];
         cbwp_pkg::CSR_HALF_Z:   half_ext[2] = val[cbwp_pkg::HALF_W-1:0];
         cbwp_pkg::CSR_RATE:     seg_rate = val[cbwp_pkg::RATE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic rand_type rand16();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'sh8000;
      if (r == 1) return 16'sh7FFF;
      return rand_type'($urandom_range(0, 65535));
   endfunction

   function automatic delta_type rand_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 55) return delta_type'($urandom_range(1, 1500));
      if (r < 65) return 16'hFFFF;
      return delta_type'($urandom_range(0, 65535));
   endfunction

   task automatic random_tick();
      send_beat(cbwp_pkg::CMD_TICK, rand_delta(), rand16(), rand16(), rand16(),
                rand16(), rand16(), rand16());
   endtask

   task automatic random_restart();
      send_beat(cbwp_pkg::CMD_RESTART, delta_type'($urandom_range(0, 65535)),
                rand16(), rand16(), rand16(), rand16(), rand16(), rand16());
   endtask

   task automatic test_directed();
      // ticks on the zero path before any restart
      send_beat(cbwp_pkg::CMD_TICK, 16'd0, 16'sh7FFF, 16'sh8000, 16'sh0001,
                16'sh7FFF, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh1234,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'd1, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_RESTART, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh0,
                16'sh8000, 16'sh7FFF, 16'shFFFF);
      send_beat(cbwp_pkg::CMD_TICK, 16'd0, 16'sh5555, 16'shAAAA, 16'sh0,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'hFFFF, 16'sh8000, 16'sh8000, 16'sh8000,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'd1000, 16'sh0100, 16'shFF00, 16'sh0F0F,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'd3000, 16'sh0100, 16'shFF00, 16'sh0F0F,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'd1, 16'sh0, 16'sh0, 16'sh0,
                16'sh7FFF, 16'sh8000, 16'sh1);
      send_beat(cbwp_pkg::CMD_TICK, 16'd0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_RESTART, 16'd0, 16'sh0, 16'sh0, 16'sh0,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'd2048, 16'shC000, 16'sh4000, 16'shFFFF,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'd2048, 16'sh3FFF, 16'shBFFF, 16'sh0001,
                16'sh0, 16'sh0, 16'sh0);
      send_beat(cbwp_pkg::CMD_TICK, 16'hFFFF, 16'sh2222, 16'shDDDD, 16'sh7FFF,
                16'sh0, 16'sh0, 16'sh0);
      drain();
   endtask

   task automatic test_register_extremes();
      csr_data_type cval [3];
      cval[0] = 32'h7FFF_FFFF;
      cval[1] = 32'h8000_0000;
      cval[2] = 32'h0000_0000;
      for (int s = 0; s < 3; s++) begin
         csr_write(cbwp_pkg::CSR_CENTER_X, cval[s]);
         csr_write(cbwp_pkg::CSR_CENTER_Y, cval[(s+1)%3]);
         csr_write(cbwp_pkg::CSR_CENTER_Z, cval[(s+2)%3]);
         csr_write(cbwp_pkg::CSR_HALF_X, s == 2 ? 32'd0 : 32'h7FFF_FFFF);
         csr_write(cbwp_pkg::CSR_HALF_Y, s == 1 ? 32'd0 : 32'h7FFF_FFFF);
         csr_write(cbwp_pkg::CSR_HALF_Z, 32'h7FFF_FFFF);
         csr_write(cbwp_pkg::CSR_RATE, s == 0 ? 32'h00FF_FFFF : 32'd1);
         send_beat(cbwp_pkg::CMD_RESTART, 16'd5, 16'sh7FFF, 16'sh8000, 16'sh4000,
                   16'sh8000, 16'sh7FFF, 16'shC000);
         send_beat(cbwp_pkg::CMD_TICK, 16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sh0,
                   16'sh0, 16'sh0, 16'sh0);
         send_beat(cbwp_pkg::CMD_TICK, 16'd1, 16'sh7FFF, 16'sh8000, 16'sh1,
                   16'sh0, 16'sh0, 16'sh0);
         for (int i = 0; i < 5; i++) random_tick();
         drain();
      end
   endtask

   task automatic randomise_registers();
      for (int ax = 0; ax < 3; ax++) begin
         case ($urandom_range(0, 4))
            0: csr_write(csr_idx_type'(cbwp_pkg::CSR_CENTER_X + ax), 32'h7FFF_FFFF);
            1: csr_write(csr_idx_type'(cbwp_pkg::CSR_CENTER_X + ax), 32'h8000_0000);
            default: csr_write(csr_idx_type'(cbwp_pkg::CSR_CENTER_X + ax),
                               $signed($urandom) >>> $urandom_range(4, 12));
         endcase
         case ($urandom_range(0, 4))
            0: csr_write(csr_idx_type'(cbwp_pkg::CSR_HALF_X + ax), 32'h7FFF_FFFF);
            1: csr_write(csr_idx_type'(cbwp_pkg::CSR_HALF_X + ax), 32'd0);
            default: csr_write(csr_idx_type'(cbwp_pkg::CSR_HALF_X + ax),
                               $urandom >> $urandom_range(1, 14));
         endcase
      end
      case ($urandom_range(0, 4))
         0: csr_write(cbwp_pkg::CSR_RATE, 32'd1);
         1: csr_write(cbwp_pkg::CSR_RATE, 32'h00FF_FFFF);
         default: csr_write(cbwp_pkg::CSR_RATE, csr_data_type'($urandom_range(1, 200000)));
      endcase
   endtask

   task automatic test_random_paths();
      for (int p = 0; p < 4; p++) begin
         randomise_registers();
         quiet = (p == 2);
         random_restart();
         for (int i = 0; i < 140; i++) begin
            if ($urandom_range(0, 99) < 6) random_restart();
            else random_tick();
         end
         drain();
      end
      quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      quiet = 1'b1;
      hold_asks = hold_asks + 1;
      random_restart();
      for (int i = 0; i < 25; i++) random_tick();
      quiet = 1'b0;
      drain();
   endtask

   // receiver stall: long hold-off on request, otherwise random gaps
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_asks != hold_done) begin
         hold_done <= hold_done + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (!quiet && r >= 70) begin
            stall_left <= (r < 94) ? $urandom_range(0, 3) : $urandom_range(20, 150);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pos.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected position beat %0d %0d %0d adv %0b",
                        rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_advanced);
         end else begin
            pos_beat_type e;
            e = pending_pos.pop_front();
            if (rsp_pos_x !== e.x || rsp_pos_y !== e.y || rsp_pos_z !== e.z ||
                rsp_advanced !== e.adv) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("position mismatch: expected %0d %0d %0d adv %0b, got %0d %0d %0d adv %0b",
                           e.x, e.y, e.z, e.adv, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_advanced);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_cubic_bspline_wander_path failed");
         $finish;
      end
   end

   initial begin
      for (int ax = 0; ax < 3; ax++) begin
         centre[ax] = 0;
         half_ext[ax] = cbwp_pkg::HALF_RESET;
         for (int k = 0; k < 4; k++) ctrl_pt[ax][k] = 0;
      end
      seg_rate = cbwp_pkg::RATE_RESET;
      path_phase = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_paths();
      if (mismatches == 0)
         $display("tb_cubic_bspline_wander_path passed");
      else
         $display("tb_cubic_bspline_wander_path failed");
      $finish;
   end

endmodule

`default_nettype wire
